// File: design/ssd_pkg.sv
package ssd_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;

   localparam int ADDR_W     = 32;
   localparam int COUNT_W    = 16;
   localparam int RATIO_W    = 8;
   localparam int ENTRY_W    = ADDR_W + 2 * COUNT_W;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [COUNT_W-1:0] REQ_FLOOR_RST    = 16'd5;
   localparam logic [RATIO_W-1:0] RATIO_MULT_RST   = 8'd3;
   localparam logic [COUNT_W-1:0] COUNT_MAX        = 16'hFFFF;

   localparam logic [CSR_INDEX_W-1:0] CSR_REQ_FLOOR  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATIO_MULT = 1'b1;

   localparam logic REQ_OBSERVE = 1'b0;
   localparam logic REQ_READ    = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROBE,
      ST_ENTRY,
      ST_READ,
      ST_JUDGE,
      ST_RESP
   } ssd_state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] req_floor;
      logic [RATIO_W-1:0] ratio_mult;
   } ssd_cfg_type;

   function automatic logic scanner_rule(input logic [COUNT_W-1:0] requests,
                                         input logic [COUNT_W-1:0] responses,
                                         input ssd_cfg_type cfg);
      logic [COUNT_W+RATIO_W-1:0] product;
      product = (COUNT_W+RATIO_W)'(cfg.ratio_mult) * (COUNT_W+RATIO_W)'(responses);
      return (requests != '0) && (requests >= cfg.req_floor) &&
             (product < (COUNT_W+RATIO_W)'(requests));
   endfunction

endpackage

// File: design/ssd_req_if.sv
interface ssd_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic        syn_flag;
   logic        ack_flag;
   logic [31:0] src_addr;
   logic [31:0] dst_addr;
   logic [7:0]  entry_index;

   modport source (output valid, output req_type, output syn_flag, output ack_flag,
                   output src_addr, output dst_addr, output entry_index, input ready);
   modport sink (input valid, input req_type, input syn_flag, input ack_flag,
                 input src_addr, input dst_addr, input entry_index, output ready);
endinterface

// File: design/ssd_rsp_if.sv
interface ssd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] host_addr;
   logic [15:0] request_count;
   logic [15:0] response_count;
   logic        is_scanner;

   modport source (output valid, output status, output host_addr, output request_count,
                   output response_count, output is_scanner, input ready);
   modport sink (input valid, input status, input host_addr, input request_count,
                 input response_count, input is_scanner, output ready);
endinterface

// File: design/ssd_ram.sv
module ssd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ssd_ctrl.sv
module ssd_ctrl #(
   parameter int TABLE_ENTRIES = ssd_pkg::TABLE_ENTRIES_DEF,
   localparam int IDX_W = $clog2(TABLE_ENTRIES),
   localparam int HASH_W = IDX_W + 1,
   localparam int SLOT_W = 1 + ssd_pkg::ADDR_W + IDX_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ssd_pkg::ssd_cfg_type        cfg,
   ssd_req_if.sink                     req_ch,
   ssd_rsp_if.source                   rsp_ch,
   output logic                        hash_wr_en,
   output logic [HASH_W-1:0]           hash_wr_addr,
   output logic [SLOT_W-1:0]           hash_wr_data,
   output logic [HASH_W-1:0]           hash_rd_addr,
   input  logic [SLOT_W-1:0]           hash_rd_data,
   output logic                        entry_wr_en,
   output logic [IDX_W-1:0]            entry_wr_addr,
   output logic [ssd_pkg::ENTRY_W-1:0] entry_wr_data,
   output logic [IDX_W-1:0]            entry_rd_addr,
   input  logic [ssd_pkg::ENTRY_W-1:0] entry_rd_data
);

   import ssd_pkg::*;

   localparam int FILL_W = IDX_W + 1;

   function automatic logic [HASH_W-1:0] hash_of(input logic [ADDR_W-1:0] a);
      logic [HASH_W-1:0] h;
      h = '0;
      for (int i = 0; i < ADDR_W; i++) begin
         h[i % HASH_W] = h[i % HASH_W] ^ a[i];
      end
      return h;
   endfunction

   ssd_state_type      state_ff, state_in;
   logic [HASH_W-1:0]  clear_ff, clear_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [HASH_W-1:0]  probe_ff, probe_in;
   logic [ADDR_W-1:0]  key_ff, key_in;
   logic               ack_ff, ack_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [1:0]         status_ff, status_in;
   logic [ADDR_W-1:0]  host_ff, host_in;
   logic [COUNT_W-1:0] rq_ff, rq_in;
   logic [COUNT_W-1:0] rs_ff, rs_in;
   logic               flag_ff, flag_in;

   logic               slot_used;
   logic [ADDR_W-1:0]  slot_addr;
   logic [IDX_W-1:0]   slot_index;
   logic               slot_hit;
   logic               table_full;
   logic               read_hit;
   logic [COUNT_W-1:0] cur_rq, cur_rs, inc_rq, inc_rs;
   logic [ADDR_W-1:0]  obs_addr;

   assign slot_used  = hash_rd_data[SLOT_W-1];
   assign slot_addr  = hash_rd_data[IDX_W +: ADDR_W];
   assign slot_index = hash_rd_data[IDX_W-1:0];
   assign slot_hit   = slot_used && (slot_addr == key_ff);
   assign table_full = (fill_ff == FILL_W'(TABLE_ENTRIES));
   assign read_hit   = 32'(req_ch.entry_index) < 32'(fill_ff);
   assign obs_addr   = req_ch.ack_flag ? req_ch.dst_addr : req_ch.src_addr;

   assign cur_rq = entry_rd_data[COUNT_W +: COUNT_W];
   assign cur_rs = entry_rd_data[COUNT_W-1:0];
   assign inc_rq = (!ack_ff && cur_rq != COUNT_MAX) ? cur_rq + 16'd1 : cur_rq;
   assign inc_rs = (ack_ff && cur_rs != COUNT_MAX) ? cur_rs + 16'd1 : cur_rs;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               if (req_ch.req_type == REQ_READ) begin
                  state_in = read_hit ? ST_READ : ST_RESP;
               end else if (req_ch.syn_flag) begin
                  state_in = ST_PROBE;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_PROBE: begin
            if (!slot_used) begin
               state_in = table_full ? ST_RESP : ST_JUDGE;
            end else if (slot_hit) begin
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: state_in = ST_JUDGE;
         ST_READ:  state_in = ST_JUDGE;
         ST_JUDGE: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ch.ready) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready  = (state_ff == ST_IDLE);
      rsp_ch.valid  = (state_ff == ST_RESP);
      hash_wr_en    = 1'b0;
      hash_wr_addr  = probe_ff;
      hash_wr_data  = {1'b1, key_ff, fill_ff[IDX_W-1:0]};
      hash_rd_addr  = probe_in;
      entry_wr_en   = 1'b0;
      entry_wr_addr = idx_ff;
      entry_wr_data = {key_ff, inc_rq, inc_rs};
      entry_rd_addr = slot_index;
      unique case (state_ff)
         ST_CLEAR: begin
            hash_wr_en   = 1'b1;
            hash_wr_addr = clear_ff;
            hash_wr_data = '0;
         end
         ST_IDLE: begin
            entry_rd_addr = IDX_W'(req_ch.entry_index);
         end
         ST_PROBE: begin
            if (!slot_used && !table_full) begin
               hash_wr_en    = 1'b1;
               entry_wr_en   = 1'b1;
               entry_wr_addr = fill_ff[IDX_W-1:0];
               entry_wr_data = {key_ff, ack_ff ? 16'd0 : 16'd1, ack_ff ? 16'd1 : 16'd0};
            end
         end
         ST_ENTRY: begin
            entry_wr_en = 1'b1;
         end
         ST_READ, ST_JUDGE, ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      clear_in  = clear_ff;
      fill_in   = fill_ff;
      probe_in  = probe_ff;
      key_in    = key_ff;
      ack_in    = ack_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      host_in   = host_ff;
      rq_in     = rq_ff;
      rs_in     = rs_ff;
      flag_in   = flag_ff;
      case (state_ff)
         ST_CLEAR: begin
            clear_in = clear_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               status_in = STATUS_OK;
               host_in   = '0;
               rq_in     = '0;
               rs_in     = '0;
               flag_in   = 1'b0;
               key_in    = obs_addr;
               ack_in    = req_ch.ack_flag;
               probe_in  = hash_of(obs_addr);
               if (req_ch.req_type == REQ_READ && !read_hit) begin
                  status_in = STATUS_EMPTY;
               end
            end
         end
         ST_PROBE: begin
            if (!slot_used) begin
               host_in = key_ff;
               if (table_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  fill_in = fill_ff + 1'b1;
                  rq_in   = ack_ff ? 16'd0 : 16'd1;
                  rs_in   = ack_ff ? 16'd1 : 16'd0;
               end
            end else if (slot_hit) begin
               idx_in = slot_index;
            end else begin
               probe_in = probe_ff + 1'b1;
            end
         end
         ST_ENTRY: begin
            host_in = key_ff;
            rq_in   = inc_rq;
            rs_in   = inc_rs;
         end
         ST_READ: begin
            host_in = entry_rd_data[ENTRY_W-1 -: ADDR_W];
            rq_in   = cur_rq;
            rs_in   = cur_rs;
         end
         ST_JUDGE: begin
            flag_in = scanner_rule(rq_ff, rs_ff, cfg);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clear_ff <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clear_ff <= clear_in;
         fill_ff  <= fill_in;
      end
      probe_ff  <= probe_in;
      key_ff    <= key_in;
      ack_ff    <= ack_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      host_ff   <= host_in;
      rq_ff     <= rq_in;
      rs_ff     <= rs_in;
      flag_ff   <= flag_in;
   end

   assign rsp_ch.status         = status_ff;
   assign rsp_ch.host_addr      = host_ff;
   assign rsp_ch.request_count  = rq_ff;
   assign rsp_ch.response_count = rs_ff;
   assign rsp_ch.is_scanner     = flag_ff;

endmodule

// File: design/syn_scan_detector.sv
// Channel  Direction  Transaction
// req_ch   in         observe one packet or read one table entry
// rsp_ch   out        one result for every request
// csr      in         write of the request floor (index 0) or the response multiplier (index 1)
//
// A request is taken only while the block is idle, and its result is held until taken.
// A request is not taken until the result of the last one is taken. A packet without SYN goes
// from idle straight to the response; a dropped host is probed first; a new host is probed and
// judged; a read is read and judged; a known host is probed, its entry updated and judged.
// A collision adds one more probe of the hash memory, which has a single read port.
// After reset all 2 * 2**clog2(TABLE_ENTRIES) slots of the hash memory are cleared, one slot a
// cycle, and no request is taken until then. Configuration writes are taken at any time.
module syn_scan_detector #(
   parameter int TABLE_ENTRIES = ssd_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [ssd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ssd_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   ssd_req_if.sink                         req_ch,
   ssd_rsp_if.source                       rsp_ch
);

   import ssd_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int HASH_W = IDX_W + 1;
   localparam int SLOT_W = 1 + ADDR_W + IDX_W;

   ssd_cfg_type cfg_ff, cfg_in;

   logic               hash_wr_en;
   logic [HASH_W-1:0]  hash_wr_addr;
   logic [SLOT_W-1:0]  hash_wr_data;
   logic [HASH_W-1:0]  hash_rd_addr;
   logic [SLOT_W-1:0]  hash_rd_data;
   logic               entry_wr_en;
   logic [IDX_W-1:0]   entry_wr_addr;
   logic [ENTRY_W-1:0] entry_wr_data;
   logic [IDX_W-1:0]   entry_rd_addr;
   logic [ENTRY_W-1:0] entry_rd_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_REQ_FLOOR:  cfg_in.req_floor = csr_wr_data;
            CSR_RATIO_MULT: cfg_in.ratio_mult = csr_wr_data[RATIO_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.req_floor  <= REQ_FLOOR_RST;
         cfg_ff.ratio_mult <= RATIO_MULT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ssd_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (2 ** HASH_W)
   ) u_hash_ram (
      .clock   (clock),
      .wr_en   (hash_wr_en),
      .wr_addr (hash_wr_addr),
      .wr_data (hash_wr_data),
      .rd_addr (hash_rd_addr),
      .rd_data (hash_rd_data)
   );

   ssd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_wr_addr),
      .wr_data (entry_wr_data),
      .rd_addr (entry_rd_addr),
      .rd_data (entry_rd_data)
   );

   ssd_ctrl #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .req_ch        (req_ch),
      .rsp_ch        (rsp_ch),
      .hash_wr_en    (hash_wr_en),
      .hash_wr_addr  (hash_wr_addr),
      .hash_wr_data  (hash_wr_data),
      .hash_rd_addr  (hash_rd_addr),
      .hash_rd_data  (hash_rd_data),
      .entry_wr_en   (entry_wr_en),
      .entry_wr_addr (entry_wr_addr),
      .entry_wr_data (entry_wr_data),
      .entry_rd_addr (entry_rd_addr),
      .entry_rd_data (entry_rd_data)
   );

`ifndef SYNTHESIS
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> !req_ch.ready)
      else $error("request taken while a result is pending");

   a_full_reports_no_counts: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.status == STATUS_FULL) |->
      (rsp_ch.request_count == '0 && rsp_ch.response_count == '0 && !rsp_ch.is_scanner))
      else $error("dropped host reported with counts");

   a_scanner_meets_minimum: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.is_scanner) |->
      (rsp_ch.request_count != '0 && rsp_ch.request_count >= cfg_ff.req_floor))
      else $error("scanner flag below the request minimum");

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ch.ready)
      else $error("request taken before the hash memory was cleared");
`endif

endmodule
